@@ design/tfc_pkg.sv @@
// Shared types, codes and character helpers for the token frequency counter.
package tfc_pkg;

    typedef enum logic [1:0] {
        CMD_PUSH = 2'd0,
        CMD_END  = 2'd1,
        CMD_READ = 2'd2,
        CMD_NONE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        CLS_NONE  = 2'd0,
        CLS_ALPHA = 2'd1,
        CLS_DIGIT = 2'd2,
        CLS_OTHER = 2'd3
    } cls_t;

    localparam logic [7:0] UPPER_A = 8'd65;
    localparam logic [7:0] UPPER_Z = 8'd90;
    localparam logic [7:0] LOWER_A = 8'd97;
    localparam logic [7:0] LOWER_Z = 8'd122;
    localparam logic [7:0] DIGIT_0 = 8'd48;
    localparam logic [7:0] DIGIT_9 = 8'd57;
    localparam logic [7:0] CASE_OFFSET = 8'd32;

    typedef struct packed {
        logic load_ring;
        logic step_ring;
        logic update;
        logic insert;
    } cell_ctl_t;

    function automatic cls_t class_of(input logic [7:0] c);
        if ((c >= UPPER_A && c <= UPPER_Z) || (c >= LOWER_A && c <= LOWER_Z)) begin
            return CLS_ALPHA;
        end
        if (c >= DIGIT_0 && c <= DIGIT_9) begin
            return CLS_DIGIT;
        end
        return CLS_OTHER;
    endfunction

    function automatic logic [7:0] fold(input logic [7:0] c);
        if (c >= UPPER_A && c <= UPPER_Z) begin
            return c + CASE_OFFSET;
        end
        return c;
    endfunction

endpackage

@@ design/tfc_cell.sv @@
// One table entry with its match logic and one stage of the ranking ring.
module tfc_cell #(
    parameter int MAX_WORDS = 256,
    parameter int WORD_LEN  = 16,
    parameter int INDEX     = 0
) (
    input  logic                                 aclk,
    input  tfc_pkg::cell_ctl_t                   ctl,
    input  logic [$clog2(MAX_WORDS+1)-1:0]       distinct,
    input  logic [WORD_LEN*8-1:0]                pend_chars,
    input  logic [$clog2(WORD_LEN+1)-1:0]        pend_len,
    input  logic [7:0]                           rank,
    input  logic [15:0]                          ring_count_in,
    input  logic [$clog2(MAX_WORDS)-1:0]         ring_idx_in,
    input  logic                                 ring_valid_in,
    output logic [15:0]                          ring_count_out,
    output logic [$clog2(MAX_WORDS)-1:0]         ring_idx_out,
    output logic                                 ring_valid_out,
    output logic                                 match,
    output logic                                 hit,
    output logic [WORD_LEN*8-1:0]                ent_chars,
    output logic [$clog2(WORD_LEN+1)-1:0]        ent_len,
    output logic [15:0]                          ent_count
);
    import tfc_pkg::*;

    localparam int IW = $clog2(MAX_WORDS);
    localparam int DW = $clog2(MAX_WORDS + 1);
    localparam int LW = $clog2(WORD_LEN + 1);
    localparam int CW = (IW > 8) ? IW : 8;
    localparam logic [IW-1:0] MY_IDX = IW'(INDEX);
    localparam logic [DW-1:0] MY_SLOT = DW'(INDEX);

    logic [7:0]    chars_reg [WORD_LEN];
    logic [LW-1:0] len_reg;
    logic [15:0]   count_reg;
    logic [15:0]   ring_count_reg;
    logic [IW-1:0] ring_idx_reg;
    logic          ring_valid_reg;
    logic [IW-1:0] pos_reg;
    logic          in_use;
    logic          beats_me;

    assign in_use = MY_SLOT < distinct;

    always_comb begin
        match = in_use && (len_reg == pend_len);
        for (int i = 0; i < WORD_LEN; i++) begin
            if (LW'(i) < pend_len && fold(chars_reg[i]) != fold(pend_chars[i*8 +: 8])) begin
                match = 1'b0;
            end
        end
    end

    assign beats_me = ring_valid_reg &&
                      ((ring_count_reg > count_reg) ||
                       (ring_count_reg == count_reg && ring_idx_reg < MY_IDX));

    assign hit = in_use && (CW'(pos_reg) == CW'(rank));

    always_ff @(posedge aclk) begin
        if (ctl.update && match && count_reg != 16'hFFFF) begin
            count_reg <= count_reg + 16'd1;
        end else if (ctl.insert && MY_SLOT == distinct) begin
            count_reg <= 16'd1;
            len_reg   <= pend_len;
            for (int i = 0; i < WORD_LEN; i++) begin
                chars_reg[i] <= pend_chars[i*8 +: 8];
            end
        end
        if (ctl.load_ring) begin
            ring_count_reg <= count_reg;
            ring_idx_reg   <= MY_IDX;
            ring_valid_reg <= in_use;
            pos_reg        <= '0;
        end else if (ctl.step_ring) begin
            ring_count_reg <= ring_count_in;
            ring_idx_reg   <= ring_idx_in;
            ring_valid_reg <= ring_valid_in;
            if (beats_me) begin
                pos_reg <= pos_reg + IW'(1);
            end
        end
    end

    assign ring_count_out = ring_count_reg;
    assign ring_idx_out   = ring_idx_reg;
    assign ring_valid_out = ring_valid_reg;
    assign ent_len        = len_reg;
    assign ent_count      = count_reg;
    always_comb begin
        for (int i = 0; i < WORD_LEN; i++) begin
            ent_chars[i*8 +: 8] = chars_reg[i];
        end
    end

endmodule

@@ design/token_frequency_counter_core.sv @@
// Top level of the token frequency counter: tokenizer, cell row and result sequencer.
//
// Input stream: s_tuser carries the command (push byte, end of text, read rank),
// s_tdata carries the byte and the rank. Output stream: one transfer per
// character of the ranked entry, m_tlast on the final one.
// Push and end commands are acted on as they are accepted: the finished token is
// compared against every cell at once and counted or inserted in the same cycle.
// During a read, counts and indexes circulate once around the ring of cells,
// each cell counting the entries that rank ahead of it; then the entry is
// picked, then its characters are delivered, one transfer per character.
// One command is handled at a time; s_tready is high only while idle.
// A read of a rank at or beyond the number of entries gives a single transfer
// with zero data, entry_valid low and m_tlast high.
// If the receiver stalls, the current transfer holds and the block waits.
// Reset empties the table, drops any open token and clears the full flag;
// table storage itself is not cleared and needs no clearing pass.
module token_frequency_counter_core #(
    parameter int MAX_WORDS = 256,
    parameter int WORD_LEN  = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // char_in [7:0], rank [15:8]
    input  logic [1:0]  s_tuser,   // cmd [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // char_out [7:0], token_count [23:8]
    output logic [1:0]  m_tuser,   // entry_valid [0], table_full [1]
    output logic        m_tlast
);
    import tfc_pkg::*;

    localparam int IW  = $clog2(MAX_WORDS);
    localparam int DW  = $clog2(MAX_WORDS + 1);
    localparam int LW  = $clog2(WORD_LEN + 1);
    localparam int XW  = $clog2(WORD_LEN);
    localparam logic [DW-1:0] FULL_CNT = DW'(MAX_WORDS);
    localparam logic [IW-1:0] LAST_STEP = IW'(MAX_WORDS - 1);

    typedef enum logic [1:0] {ST_IDLE, ST_RANK, ST_SELECT, ST_EMIT} state_t;

    state_t          state_reg;
    logic [DW-1:0]   distinct_reg;
    logic [7:0]      pend_reg [WORD_LEN];
    logic [LW-1:0]   pend_len_reg;
    cls_t            prev_cls_reg;
    logic            overflow_reg;
    logic [7:0]      rank_reg;
    logic [IW-1:0]   step_reg;
    logic [7:0]      sel_chars_reg [WORD_LEN];
    logic [LW-1:0]   sel_len_reg;
    logic [15:0]     sel_count_reg;
    logic            sel_hit_reg;
    logic [XW-1:0]   char_idx_reg;
    logic            m_valid_reg;
    logic [23:0]     m_data_reg;
    logic [1:0]      m_user_reg;
    logic            m_last_reg;

    logic            accept;
    cmd_t            cmd;
    logic [7:0]      c_in;
    cls_t            c_cls;
    logic            extend;
    logic            do_finish;
    logic            any_match;
    cell_ctl_t       ctl;
    logic [WORD_LEN*8-1:0] pend_flat;

    logic [15:0]         ring_count [MAX_WORDS];
    logic [IW-1:0]       ring_idx   [MAX_WORDS];
    logic                ring_valid [MAX_WORDS];
    logic                match_v    [MAX_WORDS];
    logic                hit_v      [MAX_WORDS];
    logic [WORD_LEN*8-1:0] e_chars  [MAX_WORDS];
    logic [LW-1:0]       e_len      [MAX_WORDS];
    logic [15:0]         e_count    [MAX_WORDS];

    logic                  any_hit;
    logic [WORD_LEN*8-1:0] or_chars;
    logic [LW-1:0]         or_len;
    logic [15:0]           or_count;
    logic                  out_free;
    logic                  is_last;

    assign accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign cmd = cmd_t'(s_tuser);
    assign c_in = s_tdata[7:0];
    assign c_cls = class_of(c_in);
    assign extend = prev_cls_reg != CLS_NONE && c_cls == prev_cls_reg && c_cls != CLS_OTHER;
    assign do_finish = accept && prev_cls_reg != CLS_NONE && pend_len_reg != '0 &&
                       ((cmd == CMD_PUSH && !extend) || cmd == CMD_END);

    always_comb begin
        for (int i = 0; i < WORD_LEN; i++) begin
            pend_flat[i*8 +: 8] = pend_reg[i];
        end
    end

    always_comb begin
        any_match = 1'b0;
        any_hit   = 1'b0;
        or_chars  = '0;
        or_len    = '0;
        or_count  = '0;
        for (int i = 0; i < MAX_WORDS; i++) begin
            any_match = any_match | match_v[i];
            any_hit   = any_hit | hit_v[i];
            if (hit_v[i]) begin
                or_chars = or_chars | e_chars[i];
                or_len   = or_len | e_len[i];
                or_count = or_count | e_count[i];
            end
        end
    end

    assign ctl.load_ring = accept && cmd == CMD_READ;
    assign ctl.step_ring = (state_reg == ST_RANK);
    assign ctl.update    = do_finish;
    assign ctl.insert    = do_finish && !any_match;

    for (genvar g = 0; g < MAX_WORDS; g++) begin : g_cell
        localparam int PREV = (g == 0) ? MAX_WORDS - 1 : g - 1;
        tfc_cell #(
            .MAX_WORDS(MAX_WORDS),
            .WORD_LEN (WORD_LEN),
            .INDEX    (g)
        ) u_cell (
            .aclk          (aclk),
            .ctl           (ctl),
            .distinct      (distinct_reg),
            .pend_chars    (pend_flat),
            .pend_len      (pend_len_reg),
            .rank          (rank_reg),
            .ring_count_in (ring_count[PREV]),
            .ring_idx_in   (ring_idx[PREV]),
            .ring_valid_in (ring_valid[PREV]),
            .ring_count_out(ring_count[g]),
            .ring_idx_out  (ring_idx[g]),
            .ring_valid_out(ring_valid[g]),
            .match         (match_v[g]),
            .hit           (hit_v[g]),
            .ent_chars     (e_chars[g]),
            .ent_len       (e_len[g]),
            .ent_count     (e_count[g])
        );
    end

    assign out_free = !m_valid_reg || m_tready;
    assign is_last  = !sel_hit_reg || (LW'(char_idx_reg) + LW'(1) == sel_len_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            distinct_reg <= '0;
            pend_len_reg <= '0;
            prev_cls_reg <= CLS_NONE;
            overflow_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (ctl.insert) begin
                if (distinct_reg == FULL_CNT) begin
                    overflow_reg <= 1'b1;
                end else begin
                    distinct_reg <= distinct_reg + DW'(1);
                end
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        case (cmd)
                            CMD_PUSH: begin
                                if (extend) begin
                                    if (pend_len_reg < LW'(WORD_LEN)) begin
                                        pend_reg[pend_len_reg[XW-1:0]] <= c_in;
                                        pend_len_reg <= pend_len_reg + LW'(1);
                                    end
                                end else begin
                                    pend_reg[0]  <= c_in;
                                    pend_len_reg <= LW'(1);
                                    prev_cls_reg <= c_cls;
                                end
                            end
                            CMD_END: begin
                                pend_len_reg <= '0;
                                prev_cls_reg <= CLS_NONE;
                            end
                            CMD_READ: begin
                                rank_reg  <= s_tdata[15:8];
                                step_reg  <= '0;
                                state_reg <= ST_RANK;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_RANK: begin
                    step_reg <= step_reg + IW'(1);
                    if (step_reg == LAST_STEP) begin
                        state_reg <= ST_SELECT;
                    end
                end
                ST_SELECT: begin
                    sel_hit_reg   <= any_hit;
                    sel_len_reg   <= or_len;
                    sel_count_reg <= or_count;
                    for (int i = 0; i < WORD_LEN; i++) begin
                        sel_chars_reg[i] <= or_chars[i*8 +: 8];
                    end
                    char_idx_reg <= '0;
                    state_reg    <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_last_reg  <= is_last;
                        m_user_reg  <= {overflow_reg, sel_hit_reg};
                        if (sel_hit_reg) begin
                            m_data_reg <= {sel_count_reg, sel_chars_reg[char_idx_reg]};
                        end else begin
                            m_data_reg <= '0;
                        end
                        char_idx_reg <= char_idx_reg + XW'(1);
                        if (is_last) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

endmodule

@@ design/tfc_checker.sv @@
// Port-level checks for the token frequency counter and their bind.
module tfc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("Result transfer dropped while stalled.");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("Block not idle after reset.");

    a_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tlast && m_tdata == 24'd0)
        else $error("Out of range read must be one empty last transfer.");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("Input taken in the middle of a read.");

endmodule

bind token_frequency_counter_core tfc_checker u_tfc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
);
